[src/nearest_mapped_point_search_defines.svh]
// Assertion macros shared by the nearest mapped point search RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef NEAREST_MAPPED_POINT_SEARCH_DEFINES_SVH
`define NEAREST_MAPPED_POINT_SEARCH_DEFINES_SVH

// Same-cycle implication.
`define NMPS_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NMPS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[src/nmps_pkg.sv]
// Package for the nearest mapped point search: sizes, command and state codes,
// entry layout and the status structs passed between the units. No dependencies.
package nmps_pkg;

   localparam int MAX_ENTRIES = 16384;
   localparam int FRAC_BITS   = 8;

   localparam int ADDR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);

   localparam int CMD_W    = 2;
   localparam int COORD_W  = 20;
   localparam int IDX_W    = 24;
   localparam int QUERY_W  = 12;
   localparam int QFIX_W   = QUERY_W + FRAC_BITS;
   localparam int DIFF_W   = (COORD_W > QFIX_W) ? COORD_W : QFIX_W;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int DIST_W   = SQ_W + 1;
   localparam int OUT_W    = 12;
   localparam int CSR_W    = 13;
   localparam int CSR_IDX_W = 1;
   localparam int DIV_CNT_W = $clog2(IDX_W + 1);

   localparam logic [CSR_W-1:0] WIDTH_RESET  = CSR_W'(640);
   localparam logic [CSR_W-1:0] HEIGHT_RESET = CSR_W'(480);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH  = 1'b0,
      CSR_MAP_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV_COL,
      ST_DIV_ROW
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [IDX_W-1:0]   index;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic idle;
      logic have;
   } near_stat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[src/nmps_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No package dependencies.
module nmps_ram #(
   parameter int DEPTH  = 16384,
   parameter int DATA_W = 64,
   parameter int ADDR_W = 14
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/nmps_nearest.sv]
// Distance and running-minimum pipeline: abs diff, square, sum, compare.
// Depends on nmps_pkg.
module nmps_nearest import nmps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               in_valid,
   input  entry_type          in_entry,
   input  logic [QFIX_W-1:0]  qx,
   input  logic [QFIX_W-1:0]  qy,
   output near_stat_type      stat,
   output logic [IDX_W-1:0]   best_index
);

   logic               va_ff, vb_ff, vc_ff, have_ff;
   logic [DIFF_W-1:0]  dx_ff, dy_ff, dx_in, dy_in;
   logic [IDX_W-1:0]   ia_ff, ib_ff, ic_ff, best_index_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic [DIST_W-1:0]  dist_ff, best_ff;
   logic [DIFF_W-1:0]  ex, ey, eqx, eqy;
   logic               take;

   always_comb begin
      ex    = DIFF_W'(in_entry.x);
      ey    = DIFF_W'(in_entry.y);
      eqx   = DIFF_W'(qx);
      eqy   = DIFF_W'(qy);
      dx_in = (ex >= eqx) ? (ex - eqx) : (eqx - ex);
      dy_in = (ey >= eqy) ? (ey - eqy) : (eqy - ey);
      take  = vc_ff && (!have_ff || (dist_ff < best_ff));
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         va_ff   <= 1'b0;
         vb_ff   <= 1'b0;
         vc_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         if (take) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      ia_ff   <= in_entry.index;
      sqx_ff  <= dx_ff * dx_ff;
      sqy_ff  <= dy_ff * dy_ff;
      ib_ff   <= ia_ff;
      dist_ff <= DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
      ic_ff   <= ib_ff;
      if (take) begin
         best_ff       <= dist_ff;
         best_index_ff <= ic_ff;
      end
   end

   assign stat.idle  = !(va_ff || vb_ff || vc_ff);
   assign stat.have  = have_ff;
   assign best_index = best_index_ff;

endmodule

[src/nmps_divider.sv]
// Restoring divider, one quotient bit per cycle, for the index split.
// Depends on nmps_pkg.
module nmps_divider import nmps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [IDX_W-1:0]  dividend,
   input  logic [CSR_W-1:0]  divisor,
   output div_stat_type      stat,
   output logic [IDX_W-1:0]  quotient,
   output logic [CSR_W-1:0]  remainder
);

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [IDX_W-1:0]     quo_ff;
   logic [CSR_W-1:0]     rem_ff, dvs_ff;
   logic [CSR_W:0]       trial;
   logic                 fits;
   logic                 done;

   always_comb begin
      trial = {rem_ff, quo_ff[IDX_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
      done  = busy_ff && (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(IDX_W);
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff && !done) begin
         quo_ff <= {quo_ff[IDX_W-2:0], fits};
         rem_ff <= fits ? CSR_W'(trial - {1'b0, dvs_ff}) : CSR_W'(trial);
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[src/nearest_mapped_point_search.sv]
// Top level of the nearest mapped point search: command decode, scan sequencer,
// result register. Depends on nmps_pkg, nmps_ram, nmps_nearest, nmps_divider.
//
// Usage:
//  - req_* carries one command per transfer: clear, append a point, or query.
//    rsp_* returns one result for each query and for each append that finds
//    the table full; clear and normal appends return nothing.
//  - csr_* writes the map width (index 0) and map height (index 1); the user
//    must write them only while idle, which the block itself does not enforce.
//  - Clear and append finish in the idle state. A query on N stored points makes
//    one RAM read per cycle over the point table, drains the read and
//    distance pipeline, then runs two 24-bit restoring divisions (index by
//    width, then by height).
//  - A query on an empty table answers at the next edge with found low.
//  - One command is in work at a time; req_stall is high while a query runs
//    and while the result register holds a result that is not taken.
//  - rsp_stall holds the result register; the next command waits behind it.
//  - Reset empties the table, loads width 640 and height 480 and drops any
//    pending result. Table contents need no clearing pass.
`include "nearest_mapped_point_search_defines.svh"

module nearest_mapped_point_search import nmps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [COORD_W-1:0]   req_point_x,
   input  logic [COORD_W-1:0]   req_point_y,
   input  logic [IDX_W-1:0]     req_pixel_index,
   input  logic [QUERY_W-1:0]   req_query_x,
   input  logic [QUERY_W-1:0]   req_query_y,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [OUT_W-1:0]     rsp_result_col,
   output logic [OUT_W-1:0]     rsp_result_row,
   output logic                 rsp_table_full,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] addr_ff, addr_in;
   logic               rd_valid_ff;
   logic [QFIX_W-1:0]  qx_ff, qy_ff;
   logic [CSR_W-1:0]   width_ff, height_ff, eff_width, eff_height;
   logic [OUT_W-1:0]   col_ff, col_in;
   logic               rsp_valid_ff, rsp_found_ff, rsp_full_ff;
   logic [OUT_W-1:0]   rsp_col_ff, rsp_row_ff;
   logic               rsp_found_in, rsp_full_in;
   logic [OUT_W-1:0]   rsp_col_in, rsp_row_in;

   logic               req_accept, rsp_free, table_full;
   logic               ram_we, rd_en, scan_start, rsp_load, div_start;
   logic [IDX_W-1:0]   div_dividend;
   logic [CSR_W-1:0]   div_divisor;
   entry_type          wr_entry, rd_entry;
   logic [ENTRY_W-1:0] rd_data;
   near_stat_type      near_stat;
   logic [IDX_W-1:0]   best_index;
   div_stat_type       div_stat;
   logic [IDX_W-1:0]   div_quotient;
   logic [CSR_W-1:0]   div_remainder;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && rsp_free);
   assign req_accept = req_valid && !req_stall;
   assign table_full = count_ff == COUNT_W'(MAX_ENTRIES);
   assign eff_width  = (width_ff == '0) ? CSR_W'(1) : width_ff;
   assign eff_height = (height_ff == '0) ? CSR_W'(1) : height_ff;

   assign wr_entry.x     = req_point_x;
   assign wr_entry.y     = req_point_y;
   assign wr_entry.index = req_pixel_index;
   assign rd_entry       = entry_type'(rd_data);

   nmps_ram #(
      .DEPTH  (MAX_ENTRIES),
      .DATA_W (ENTRY_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   nmps_nearest u_nearest (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .in_valid   (rd_valid_ff),
      .in_entry   (rd_entry),
      .qx         (qx_ff),
      .qy         (qy_ff),
      .stat       (near_stat),
      .best_index (best_index)
   );

   nmps_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_en;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_MAP_WIDTH:  width_ff  <= csr_wdata;
               CSR_MAP_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      col_ff  <= col_in;
      if (req_accept) begin
         qx_ff <= {req_query_x, FRAC_BITS'(0)};
         qy_ff <= {req_query_y, FRAC_BITS'(0)};
      end
      if (rsp_load) begin
         rsp_found_ff <= rsp_found_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_row_ff   <= rsp_row_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      col_in       = col_ff;
      ram_we       = 1'b0;
      rd_en        = 1'b0;
      scan_start   = 1'b0;
      div_start    = 1'b0;
      div_dividend = best_index;
      div_divisor  = eff_width;
      rsp_load     = 1'b0;
      rsp_found_in = 1'b0;
      rsp_col_in   = '0;
      rsp_row_in   = '0;
      rsp_full_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (cmd_type'(req_cmd))
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_APPEND: begin
                     if (table_full) begin
                        rsp_load    = 1'b1;
                        rsp_full_in = 1'b1;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_load = 1'b1;
                     end else begin
                        scan_start = 1'b1;
                        addr_in    = '0;
                        state_in   = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_in == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && near_stat.idle) begin
               div_start = 1'b1;
               state_in  = ST_DIV_COL;
            end
         end
         ST_DIV_COL: begin
            if (div_stat.done) begin
               col_in       = OUT_W'(div_remainder);
               div_start    = 1'b1;
               div_dividend = div_quotient;
               div_divisor  = eff_height;
               state_in     = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            if (div_stat.done) begin
               rsp_load     = 1'b1;
               rsp_found_in = near_stat.have;
               rsp_col_in   = col_ff;
               rsp_row_in   = OUT_W'(div_remainder);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_result_col = rsp_col_ff;
   assign rsp_result_row = rsp_row_ff;
   assign rsp_table_full = rsp_full_ff;

   `NMPS_ASSERT_SAME(a_no_write_in_query, state_ff != ST_IDLE, !ram_we, "table write during query")
   `NMPS_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= COUNT_W'(MAX_ENTRIES), "entry count overflow")
   `NMPS_ASSERT_SAME(a_load_free, rsp_load, !rsp_valid_ff || !rsp_stall, "result overwritten")
   `NMPS_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy || div_stat.done, "divider restarted")
   `NMPS_ASSERT_NEXT(a_scan_in_range, state_ff == ST_SCAN, count_ff != '0, "scan of empty table")

endmodule

[tb/nearest_mapped_point_search_tb.sv]
`timescale 1ns / 100ps
// Testbench for nearest_mapped_point_search: random and directed commands with a
// scoreboard that keeps its own point table. Depends on nmps_pkg and the RTL only.
module nearest_mapped_point_search_tb import nmps_pkg::*; ();

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD     = 300;
   localparam int ITEMS_PER_MAP = 14;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic [IDX_W-1:0]   pixel_index;
      logic [QUERY_W-1:0] query_x;
      logic [QUERY_W-1:0] query_y;
   } request_type;

   typedef struct packed {
      logic             found;
      logic [OUT_W-1:0] col;
      logic [OUT_W-1:0] row;
      logic             full;
   } answer_type;

   class nearest_point_board;
      logic [COORD_W-1:0] stored_x [MAX_ENTRIES];
      logic [COORD_W-1:0] stored_y [MAX_ENTRIES];
      logic [IDX_W-1:0]   stored_index [MAX_ENTRIES];
      int unsigned        stored_count;
      logic [CSR_W-1:0]   grid_w;
      logic [CSR_W-1:0]   grid_h;
      answer_type         awaited_answers[$];
      int unsigned        errors;
      int unsigned        found_count;
      int unsigned        empty_count;
      int unsigned        full_count;
      int unsigned        peak_count;

      function new();
         stored_count = 0;
         grid_w       = WIDTH_RESET;
         grid_h       = HEIGHT_RESET;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_W-1:0] value);
         if (idx == CSR_MAP_WIDTH) grid_w = value;
         else grid_h = value;
      endfunction

      function int unsigned pending();
         return awaited_answers.size();
      endfunction

      function void note_request(request_type r);
         logic [41:0] qfx, qfy, dx, dy, sq_dist, best;
         int unsigned best_index, w, h;
         answer_type a;
         a = '0;
         case (r.cmd)
            CMD_CLEAR: stored_count = 0;
            CMD_APPEND: begin
               if (stored_count >= MAX_ENTRIES) begin
                  a.full = 1'b1;
                  awaited_answers = {awaited_answers, a};
                  full_count++;
               end else begin
                  stored_x[stored_count]     = r.point_x;
                  stored_y[stored_count]     = r.point_y;
                  stored_index[stored_count] = r.pixel_index;
                  stored_count++;
                  if (stored_count > peak_count) peak_count = stored_count;
               end
            end
            CMD_QUERY: begin
               qfx = 42'(r.query_x) << FRAC_BITS;
               qfy = 42'(r.query_y) << FRAC_BITS;
               best = '0;
               best_index = 0;
               for (int i = 0; i < stored_count; i++) begin
                  dx = (stored_x[i] >= qfx) ? stored_x[i] - qfx : qfx - stored_x[i];
                  dy = (stored_y[i] >= qfy) ? stored_y[i] - qfy : qfy - stored_y[i];
                  sq_dist = dx * dx + dy * dy;
                  if (i == 0 || sq_dist < best) begin
                     best = sq_dist;
                     best_index = stored_index[i];
                  end
               end
               if (stored_count == 0) begin
                  empty_count++;
               end else begin
                  w = (grid_w == 0) ? 1 : grid_w;
                  h = (grid_h == 0) ? 1 : grid_h;
                  a.found = 1'b1;
                  a.col = OUT_W'(best_index % w);
                  a.row = OUT_W'((best_index / w) % h);
                  found_count++;
               end
               awaited_answers = {awaited_answers, a};
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic found, logic [OUT_W-1:0] col,
                                 logic [OUT_W-1:0] row, logic full);
         answer_type e;
         if (awaited_answers.size() == 0) begin
            $error("result transfer with nothing expected: found %0d col %0d row %0d full %0d",
                   found, col, row, full);
            errors++;
            return;
         end
         e = awaited_answers.pop_front();
         if (found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, found);
            errors++;
         end
         if (col !== e.col) begin
            $error("result_col: expected %0d, got %0d", e.col, col);
            errors++;
         end
         if (row !== e.row) begin
            $error("result_row: expected %0d, got %0d", e.row, row);
            errors++;
         end
         if (full !== e.full) begin
            $error("table_full: expected %0d, got %0d", e.full, full);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd;
   logic [COORD_W-1:0]   req_point_x;
   logic [COORD_W-1:0]   req_point_y;
   logic [IDX_W-1:0]     req_pixel_index;
   logic [QUERY_W-1:0]   req_query_x;
   logic [QUERY_W-1:0]   req_query_y;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_found;
   logic [OUT_W-1:0]     rsp_result_col;
   logic [OUT_W-1:0]     rsp_result_row;
   logic                 rsp_table_full;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   nearest_point_board board = new();
   bit          steady_flow = 1'b0;
   int unsigned hold_off_asked = 0;
   int unsigned hold_off_served = 0;
   int unsigned counted_items = 0;
   int unsigned map_settings = 0;

   nearest_mapped_point_search dut (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      #5_000_000;
      $display("nearest_mapped_point_search_tb: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_found, rsp_result_col, rsp_result_row, rsp_table_full);
   end

   initial begin
      int unsigned run_left;
      bit          level;
      run_left = 0;
      level = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_asked != hold_off_served) begin
            hold_off_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            run_left = 0;
         end else if (steady_flow) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run_left == 0) begin
               level = ($urandom_range(0, 2) == 0);
               if (!level) run_left = $urandom_range(1, 12);
               else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(20, 60);
               else run_left = $urandom_range(1, 3);
            end
            run_left--;
            rsp_stall <= level;
         end
      end
   end

   function automatic int unsigned sender_gap();
      int unsigned pick;
      if (steady_flow) return 0;
      pick = $urandom_range(0, 9);
      if (pick < 6) return 0;
      if (pick < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic request_type random_request(logic [CMD_W-1:0] cmd);
      request_type r;
      r.cmd         = cmd;
      r.point_x     = COORD_W'($urandom);
      r.point_y     = COORD_W'($urandom);
      r.pixel_index = IDX_W'($urandom);
      r.query_x     = QUERY_W'($urandom);
      r.query_y     = QUERY_W'($urandom);
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] near_coord(logic [QUERY_W-1:0] q);
      int v;
      v = (int'(q) << FRAC_BITS) + int'($urandom_range(0, 4096)) - 2048;
      if (v < 0) v = 0;
      if (v > (1 << COORD_W) - 1) v = (1 << COORD_W) - 1;
      return v[COORD_W-1:0];
   endfunction

   task automatic send_request(input request_type r);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_cmd         <= r.cmd;
      req_point_x     <= r.point_x;
      req_point_y     <= r.point_y;
      req_pixel_index <= r.pixel_index;
      req_query_x     <= r.query_x;
      req_query_y     <= r.query_y;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      if (r.cmd != CMD_UNUSED) counted_items++;
      gap = sender_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_append(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [IDX_W-1:0] index);
      request_type r;
      r = random_request(CMD_APPEND);
      r.point_x = x;
      r.point_y = y;
      r.pixel_index = index;
      send_request(r);
   endtask

   task automatic send_query(logic [QUERY_W-1:0] qx, logic [QUERY_W-1:0] qy);
      request_type r;
      r = random_request(CMD_QUERY);
      r.query_x = qx;
      r.query_y = qy;
      send_request(r);
   endtask

   task automatic settle();
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_map(logic [CSR_W-1:0] w, logic [CSR_W-1:0] h);
      req_valid <= 1'b0;
      settle();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MAP_WIDTH;
      csr_wdata    <= w;
      @(posedge clock);
      board.set_register(CSR_MAP_WIDTH, w);
      csr_index <= CSR_MAP_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      board.set_register(CSR_MAP_HEIGHT, h);
      csr_write_en <= 1'b0;
      map_settings++;
   endtask

   task automatic run_batch();
      request_type        r;
      int unsigned        n;
      int unsigned        kind;
      logic [QUERY_W-1:0] cx, cy;
      logic [COORD_W-1:0] lx, ly;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         send_request(random_request(CMD_UNUSED));
         send_request(random_request(CMD_QUERY));
      end else if (kind == 1) begin
         send_request(random_request(CMD_CLEAR));
         send_request(random_request(CMD_QUERY));
      end else begin
         cx = QUERY_W'($urandom);
         cy = QUERY_W'($urandom);
         lx = COORD_W'($urandom);
         ly = COORD_W'($urandom);
         send_request(random_request(CMD_CLEAR));
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         repeat (n) begin
            r = random_request(CMD_APPEND);
            case ($urandom_range(0, 7))
               0: begin
                  r.point_x = lx;
                  r.point_y = ly;
               end
               1, 2, 3: begin
                  r.point_x = near_coord(cx);
                  r.point_y = near_coord(cy);
               end
               default: ;
            endcase
            lx = r.point_x;
            ly = r.point_y;
            send_request(r);
         end
         send_query(cx, cy);
         repeat ($urandom_range(0, 2)) send_request(random_request(CMD_QUERY));
      end
   endtask

   initial begin
      int unsigned base;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_CLEAR;
      req_point_x     = '0;
      req_point_y     = '0;
      req_pixel_index = '0;
      req_query_x     = '0;
      req_query_y     = '0;
      csr_write_en    = 1'b0;
      csr_index       = CSR_MAP_WIDTH;
      csr_wdata       = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_query(12'd0, 12'd0);
      send_request(random_request(CMD_UNUSED));
      send_append('0, '0, '0);
      send_append('1, '1, '1);
      send_query(12'd0, 12'd0);
      send_query('1, '1);
      send_append(20'h00A00, 20'h00500, 24'd1234);
      send_append(20'h00A00, 20'h00500, 24'd99);
      send_query(12'd10, 12'd5);
      send_append(20'h00A80, 20'h00580, 24'h5A5A5A);
      send_query(12'd11, 12'd6);
      send_request(random_request(CMD_CLEAR));
      send_query(12'd7, 12'd7);
      send_request(random_request(CMD_APPEND));
      send_request(random_request(CMD_QUERY));

      base = counted_items;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: configure_map(13'd1, 13'd1);
            1: configure_map(13'd8191, 13'd8191);
            2: configure_map(13'd0, 13'd0);
            3: configure_map(13'd4096, 13'd4096);
            4: configure_map(13'd1, 13'd8191);
            default: configure_map(CSR_W'($urandom_range(1, 4096)),
                                   CSR_W'($urandom_range(1, 4096)));
         endcase
         steady_flow = ($urandom_range(0, 3) == 0);
         while (counted_items < base + ITEMS_PER_MAP * (p + 1)) run_batch();
         if (p == 2) begin
            send_request(random_request(CMD_CLEAR));
            repeat (3) send_request(random_request(CMD_APPEND));
            steady_flow = 1'b1;
            hold_off_asked++;
            repeat (8) send_request(random_request(CMD_QUERY));
         end
         steady_flow = 1'b0;
      end

      configure_map(CSR_W'($urandom_range(1, 4096)), CSR_W'($urandom_range(1, 4096)));
      send_request(random_request(CMD_APPEND));
      send_request(random_request(CMD_QUERY));
      send_request(random_request(CMD_CLEAR));
      send_request(random_request(CMD_APPEND));
      send_request(random_request(CMD_QUERY));

      req_valid <= 1'b0;
      settle();
      $display("nearest_mapped_point_search_tb: %0d commands over %0d map settings, peak table %0d",
               counted_items, map_settings, board.peak_count);
      $display("nearest_mapped_point_search_tb: %0d hits, %0d empty-table queries, %0d full drops",
               board.found_count, board.empty_count, board.full_count);
      if (board.errors == 0) begin
         $display("nearest_mapped_point_search_tb: done, clean");
      end else begin
         $display("nearest_mapped_point_search_tb: done, errors");
      end
      $finish;
   end

endmodule
